>>> rtl/slpm_pkg.sv
// Package for the status LED priority monitor: stream and config widths,
// register indexes and reset values, command codes, colours and the config struct.
// No dependencies.
`default_nettype none

package slpm_pkg;

    // Time stamp width default
    localparam int TIME_WIDTH_DEF = 32;

    // Stream payload widths
    localparam int NOW_W      = 32;
    localparam int CUR_W      = 20;
    localparam int IN_DATA_W  = 80;   // 78 bits of fields, padded to bytes
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;   // 27 bits of fields, padded to bytes
    localparam int COLOUR_W   = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int HOLD_W     = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_HOLD = 3'd4;

    localparam logic [19:0] TICK_PERIOD_RST   = 20'd10000;
    localparam logic [23:0] POLL_PERIOD_RST   = 24'd100000;
    localparam logic [18:0] CURRENT_LIMIT_RST = 19'd50000;
    localparam logic [26:0] FAULT_HOLD_RST    = 27'd1000000;
    localparam logic [26:0] ACTIVITY_HOLD_RST = 27'd200000;

    // Transaction kinds carried in tuser
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Probe commands that count as activity
    localparam logic [7:0] CMD_XFER_A = 8'h05;  // ack in response byte 2
    localparam logic [7:0] CMD_XFER_B = 8'h06;  // ack in response byte 3
    localparam logic [7:0] CMD_XFER_C = 8'h7f;  // no ack byte
    localparam logic [7:0] ACK_FAULT_MASK = 8'h1c;

    // Current saturation bounds
    localparam logic signed [CUR_W-1:0] CUR_MAX = 20'sd400000;
    localparam logic signed [CUR_W-1:0] CUR_MIN = -20'sd400000;

    // LED colours, GRB order
    localparam logic [COLOUR_W-1:0] COL_RED   = 24'h001400;
    localparam logic [COLOUR_W-1:0] COL_AMBER = 24'h081200;
    localparam logic [COLOUR_W-1:0] COL_GREEN = 24'h0c0000;
    localparam logic [COLOUR_W-1:0] COL_BLUE  = 24'h00000c;

    typedef struct packed {
        logic [19:0]       tick_period;
        logic [23:0]       poll_period;
        logic [18:0]       current_limit;
        logic [HOLD_W-1:0] fault_hold;
        logic [HOLD_W-1:0] activity_hold;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/status_led_priority_monitor.sv
// Status LED priority monitor: stamps probe activity and faults, gates ticks,
// takes sensor polls and picks the LED colour. Depends on slpm_pkg, slpm_cfg.
//
// Timing: an accepted tick sits in the input register, and the evaluation stage
// then loads the result register. Throughput: one transaction per cycle unless
// a result meets a full output; the evaluation stage reads and updates the time
// stamps in the same cycle, so back-to-back items chain.
// Reset (synchronous, active low): stamps, flags and stored current clear,
// sent colour returns to blue, config registers take their defaults.
`default_nettype none

module status_led_priority_monitor #(
    parameter int TIME_WIDTH = slpm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_us[31:0], command[39:32], resp_byte_two[47:40], resp_byte_three[55:48],
    // poll_ok[56], poll current[76:57], usb_ready[77], zero pad [79:78]
    input  wire logic [slpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  wire logic [slpm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // led_grb[23:0], led_write[24], poll_due[25], over-limit flag[26], zero pad [31:27]
    output logic [slpm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [slpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slpm_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

    t_cfg w_cfg;

    slpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Input register
    logic                    r_in_valid;
    logic                    r_op;
    logic [NOW_W-1:0]        r_now;
    logic [7:0]              r_cmd;
    logic [7:0]              r_byte_two;
    logic [7:0]              r_byte_three;
    logic                    r_poll_ok;
    logic signed [CUR_W-1:0] r_cur_in;
    logic                    r_usb_ready;

    // Monitor state
    logic [TIME_WIDTH-1:0]   r_tick_stamp;
    logic [TIME_WIDTH-1:0]   r_poll_stamp;
    logic [TIME_WIDTH-1:0]   r_activity_stamp;
    logic [TIME_WIDTH-1:0]   r_fault_stamp;
    logic                    r_activity_seen;
    logic                    r_fault_seen;
    logic                    r_sensor_healthy;
    logic signed [CUR_W-1:0] r_stored_current;
    logic [COLOUR_W-1:0]     r_sent_colour;

    // Result register
    logic                    r_out_valid;
    logic [COLOUR_W-1:0]     r_led_grb;
    logic                    r_led_write;
    logic                    r_poll_due;
    logic                    r_over_limit;

    // Evaluation stage signals
    logic                    w_s1_emit;
    logic                    w_s1_go;
    logic                    w_s1_fire;
    logic                    w_in_fire;
    logic [TIME_WIDTH-1:0]   w_now;
    logic [TIME_WIDTH-1:0]   w_tick_dt;
    logic [TIME_WIDTH-1:0]   w_poll_dt;
    logic [TIME_WIDTH-1:0]   w_fault_dt;
    logic [TIME_WIDTH-1:0]   w_activity_dt;
    logic                    w_cmd_hit;
    logic [7:0]              w_ack;
    logic                    w_ack_fault;
    logic                    w_tick_pass;
    logic                    w_poll_due;
    logic                    w_fault_recent;
    logic                    w_activity_recent;
    logic signed [CUR_W-1:0] w_cur_sat;
    logic                    n_sensor_healthy;
    logic signed [CUR_W-1:0] n_stored_current;
    logic                    w_over;
    logic [COLOUR_W-1:0]     w_colour;

    // Handshake: stage 1 stalls only when it holds a result and the output is full
    assign w_s1_go       = !w_s1_emit || !r_out_valid || m_axis_tready;
    assign w_s1_fire     = r_in_valid && w_s1_go;
    assign s_axis_tready = !r_in_valid || w_s1_go;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // Transfer event decode
    always_comb begin
        w_cmd_hit = 1'b0;
        w_ack     = 8'h00;
        case (r_cmd)
            CMD_XFER_A: begin
                w_cmd_hit = 1'b1;
                w_ack     = r_byte_two;
            end
            CMD_XFER_B: begin
                w_cmd_hit = 1'b1;
                w_ack     = r_byte_three;
            end
            CMD_XFER_C: begin
                w_cmd_hit = 1'b1;
            end
            default: begin
                w_cmd_hit = 1'b0;
            end
        endcase
    end
    assign w_ack_fault = |(w_ack & ACK_FAULT_MASK);

    // Wrap-safe elapsed-time gates; differences wrap at the time width
    assign w_now         = TIME_WIDTH'(r_now);
    assign w_tick_dt     = w_now - r_tick_stamp;
    assign w_poll_dt     = w_now - r_poll_stamp;
    assign w_fault_dt    = w_now - r_fault_stamp;
    assign w_activity_dt = w_now - r_activity_stamp;
    assign w_tick_pass = CMP_W'(w_tick_dt) >= CMP_W'(w_cfg.tick_period);
    assign w_poll_due  = CMP_W'(w_poll_dt) >= CMP_W'(w_cfg.poll_period);
    assign w_fault_recent = r_fault_seen &&
        (CMP_W'(w_fault_dt) < CMP_W'(w_cfg.fault_hold));
    assign w_activity_recent = r_activity_seen &&
        (CMP_W'(w_activity_dt) < CMP_W'(w_cfg.activity_hold));

    // Poll outcome with current saturation
    always_comb begin
        if (r_cur_in > CUR_MAX) begin
            w_cur_sat = CUR_MAX;
        end else if (r_cur_in < CUR_MIN) begin
            w_cur_sat = CUR_MIN;
        end else begin
            w_cur_sat = r_cur_in;
        end
    end
    assign n_sensor_healthy = w_poll_due ? r_poll_ok : r_sensor_healthy;
    assign n_stored_current = (w_poll_due && r_poll_ok) ? w_cur_sat : r_stored_current;
    assign w_over = n_stored_current > $signed({1'b0, w_cfg.current_limit});

    // Colour priority: red, amber, green, blue
    always_comb begin
        if (!n_sensor_healthy || w_over || w_fault_recent) begin
            w_colour = COL_RED;
        end else if (w_activity_recent) begin
            w_colour = COL_AMBER;
        end else if (r_usb_ready) begin
            w_colour = COL_GREEN;
        end else begin
            w_colour = COL_BLUE;
        end
    end

    assign w_s1_emit = (r_op == OP_TICK) && w_tick_pass;

    // Input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op         <= s_axis_tuser[0];
            r_now        <= s_axis_tdata[31:0];
            r_cmd        <= s_axis_tdata[39:32];
            r_byte_two   <= s_axis_tdata[47:40];
            r_byte_three <= s_axis_tdata[55:48];
            r_poll_ok    <= s_axis_tdata[56];
            r_cur_in     <= s_axis_tdata[76:57];
            r_usb_ready  <= s_axis_tdata[77];
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_stamp     <= '0;
            r_poll_stamp     <= '0;
            r_activity_stamp <= '0;
            r_fault_stamp    <= '0;
            r_activity_seen  <= 1'b0;
            r_fault_seen     <= 1'b0;
            r_sensor_healthy <= 1'b0;
            r_stored_current <= '0;
            r_sent_colour    <= COL_BLUE;
        end else if (w_s1_fire) begin
            if (r_op == OP_EVENT) begin
                if (w_cmd_hit) begin
                    r_activity_stamp <= w_now;
                    r_activity_seen  <= 1'b1;
                    if (w_ack_fault) begin
                        r_fault_stamp <= w_now;
                        r_fault_seen  <= 1'b1;
                    end
                end
            end else if (w_tick_pass) begin
                r_tick_stamp     <= w_now;
                r_sensor_healthy <= n_sensor_healthy;
                r_stored_current <= n_stored_current;
                r_sent_colour    <= w_colour;
                if (w_poll_due) begin
                    r_poll_stamp <= w_now;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && w_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && w_s1_emit) begin
            r_led_grb    <= w_colour;
            r_led_write  <= (w_colour != r_sent_colour);
            r_poll_due   <= w_poll_due;
            r_over_limit <= w_over;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_over_limit, r_poll_due, r_led_write, r_led_grb};

endmodule

`default_nettype wire

>>> rtl/slpm_cfg.sv
// Configuration register file of the status LED priority monitor.
// Depends on slpm_pkg.
`default_nettype none

module slpm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [slpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output slpm_pkg::t_cfg                      o_cfg
);
    import slpm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Index decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_PERIOD:   n_cfg.tick_period   = i_cfg_data[19:0];
                CFG_POLL_PERIOD:   n_cfg.poll_period   = i_cfg_data[23:0];
                CFG_CURRENT_LIMIT: n_cfg.current_limit = i_cfg_data[18:0];
                CFG_FAULT_HOLD:    n_cfg.fault_hold    = i_cfg_data[HOLD_W-1:0];
                CFG_ACTIVITY_HOLD: n_cfg.activity_hold = i_cfg_data[HOLD_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period   <= TICK_PERIOD_RST;
            r_cfg.poll_period   <= POLL_PERIOD_RST;
            r_cfg.current_limit <= CURRENT_LIMIT_RST;
            r_cfg.fault_hold    <= FAULT_HOLD_RST;
            r_cfg.activity_hold <= ACTIVITY_HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> tb/status_led_priority_monitor_tb.sv
// Self-checking testbench for status_led_priority_monitor: drives probe transfer events
// and time ticks, predicts each LED result in-line and checks the result stream.
// Depends on slpm_pkg and the status_led_priority_monitor RTL.
module status_led_priority_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slpm_pkg::*;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 8;     // covers the pipeline and then some
    localparam int RESET_CYCLES  = 11;

    typedef struct {
        logic               op;
        logic [31:0]        now;
        logic [7:0]         cmd;
        logic [7:0]         resp2;
        logic [7:0]         resp3;
        logic               poll_ok;
        logic signed [19:0] cur;
        logic               usb;
    } probe_item_t;

    typedef struct {
        logic [23:0] colour;
        logic        led_write;
        logic        poll_due;
        logic        over;
    } led_status_t;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state and configuration copy
    t_cfg               model_cfg;
    logic [31:0]        last_tick_us;
    logic [31:0]        last_poll_us;
    logic [31:0]        last_activity_us;
    logic [31:0]        last_fault_us;
    bit                 activity_flag;
    bit                 fault_flag;
    bit                 sensor_good;
    logic signed [19:0] held_cur;
    logic [23:0]        last_colour;

    led_status_t pending_led[$];
    led_status_t seen_led;
    led_status_t want_led;

    // Bookkeeping
    bit          idle_on = 1'b1;
    int          rx_stall = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          xfers_sent = 0;
    int          ticks_sent = 0;
    int          settings_applied = 0;
    logic [31:0] sim_now_us;

    status_led_priority_monitor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predictor: state back to its reset values
    task automatic clear_led_model();
        model_cfg.tick_period   = TICK_PERIOD_RST;
        model_cfg.poll_period   = POLL_PERIOD_RST;
        model_cfg.current_limit = CURRENT_LIMIT_RST;
        model_cfg.fault_hold    = FAULT_HOLD_RST;
        model_cfg.activity_hold = ACTIVITY_HOLD_RST;
        last_tick_us     = '0;
        last_poll_us     = '0;
        last_activity_us = '0;
        last_fault_us    = '0;
        activity_flag    = 1'b0;
        fault_flag       = 1'b0;
        sensor_good      = 1'b0;
        held_cur         = '0;
        last_colour      = COL_BLUE;
    endtask

    // Predictor: update state for one item, return 1 when it yields an LED result
    function automatic bit predict_led_status(input probe_item_t it, output led_status_t res);
        logic [31:0] since_tick;
        logic [31:0] since_poll;
        logic [31:0] since_fault;
        logic [31:0] since_activity;
        int          cur_i;
        int          lim_i;
        bit          due;
        bit          over;
        logic [23:0] colour;
        res = '{default: '0};
        if (it.op == OP_EVENT) begin
            if (it.cmd == CMD_XFER_A || it.cmd == CMD_XFER_B || it.cmd == CMD_XFER_C) begin
                last_activity_us = it.now;
                activity_flag    = 1'b1;
                if ((it.cmd == CMD_XFER_A && (it.resp2 & ACK_FAULT_MASK) != 0) ||
                    (it.cmd == CMD_XFER_B && (it.resp3 & ACK_FAULT_MASK) != 0)) begin
                    last_fault_us = it.now;
                    fault_flag    = 1'b1;
                end
            end
            return 1'b0;
        end
        // period gate
        since_tick = it.now - last_tick_us;
        if (since_tick < 32'(model_cfg.tick_period))
            return 1'b0;
        last_tick_us = it.now;
        // sensor poll riding on this tick
        since_poll = it.now - last_poll_us;
        due = (since_poll >= 32'(model_cfg.poll_period));
        if (due) begin
            last_poll_us = it.now;
            sensor_good  = it.poll_ok;
            if (it.poll_ok) begin
                cur_i = int'(it.cur);
                if (cur_i > int'(CUR_MAX)) cur_i = int'(CUR_MAX);
                if (cur_i < int'(CUR_MIN)) cur_i = int'(CUR_MIN);
                held_cur = 20'(cur_i);
            end
        end
        cur_i = int'(held_cur);
        lim_i = int'(model_cfg.current_limit);
        over  = (cur_i > lim_i);
        // colour priority
        since_fault    = it.now - last_fault_us;
        since_activity = it.now - last_activity_us;
        if (!sensor_good || over ||
            (fault_flag && since_fault < 32'(model_cfg.fault_hold)))
            colour = COL_RED;
        else if (activity_flag && since_activity < 32'(model_cfg.activity_hold))
            colour = COL_AMBER;
        else if (it.usb)
            colour = COL_GREEN;
        else
            colour = COL_BLUE;
        res.colour    = colour;
        res.led_write = (colour != last_colour);
        res.poll_due  = due;
        res.over      = over;
        last_colour   = colour;
        return 1'b1;
    endfunction

    // Result checker: each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_led.colour    = m_axis_tdata[23:0];
            seen_led.led_write = m_axis_tdata[24];
            seen_led.poll_due  = m_axis_tdata[25];
            seen_led.over      = m_axis_tdata[26];
            results_checked++;
            if (pending_led.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: led %06h write %0b poll %0b over %0b",
                             $realtime, seen_led.colour, seen_led.led_write,
                             seen_led.poll_due, seen_led.over);
            end else begin
                want_led = pending_led.pop_front();
                if (seen_led.colour !== want_led.colour ||
                    seen_led.led_write !== want_led.led_write ||
                    seen_led.poll_due !== want_led.poll_due ||
                    seen_led.over !== want_led.over) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] mismatch: expected led %06h write %0b poll %0b over %0b,",
                                  " got led %06h write %0b poll %0b over %0b"},
                                 $realtime, want_led.colour, want_led.led_write,
                                 want_led.poll_due, want_led.over, seen_led.colour,
                                 seen_led.led_write, seen_led.poll_due, seen_led.over);
                end
            end
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
                $display("status_led_priority_monitor regression: fail");
                $finish;
            end
        end
    end

    // Send one item; predict at the accepting edge
    task automatic send_item(input probe_item_t it);
        int          gap;
        led_status_t res;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, it.usb, it.cur, it.poll_ok, it.resp3, it.resp2, it.cmd, it.now};
        s_axis_tuser  = it.op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.op == OP_TICK) ticks_sent++;
        else xfers_sent++;
        if (predict_led_status(it, res))
            pending_led.push_back(res);
    endtask

    task automatic send_tick(input logic [31:0] now, input bit ok, input logic [19:0] cur,
                             input bit usb);
        probe_item_t it;
        it.op      = OP_TICK;
        it.now     = now;
        it.cmd     = 8'($urandom);  // ignored on ticks
        it.resp2   = 8'($urandom);
        it.resp3   = 8'($urandom);
        it.poll_ok = ok;
        it.cur     = cur;
        it.usb     = usb;
        send_item(it);
    endtask

    task automatic send_xfer(input logic [31:0] now, input logic [7:0] cmd,
                             input logic [7:0] r2, input logic [7:0] r3);
        probe_item_t it;
        it.op      = OP_EVENT;
        it.now     = now;
        it.cmd     = cmd;
        it.resp2   = r2;
        it.resp3   = r3;
        it.poll_ok = 1'($urandom);  // ignored on transfers
        it.cur     = 20'($urandom);
        it.usb     = 1'($urandom);
        send_item(it);
    endtask

    // Stop sending and wait until every expected result is in
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_led.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TICK_PERIOD:   model_cfg.tick_period   = data[19:0];
            CFG_POLL_PERIOD:   model_cfg.poll_period   = data[23:0];
            CFG_CURRENT_LIMIT: model_cfg.current_limit = data[18:0];
            CFG_FAULT_HOLD:    model_cfg.fault_hold    = data[26:0];
            CFG_ACTIVITY_HOLD: model_cfg.activity_hold = data[26:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Program all five registers while the block is idle
    task automatic apply_settings(input logic [19:0] tick_p, input logic [23:0] poll_p,
                                  input logic [18:0] limit, input logic [26:0] fault_h,
                                  input logic [26:0] act_h);
        wait_drained();
        write_cfg(CFG_TICK_PERIOD, 27'(tick_p));
        write_cfg(CFG_POLL_PERIOD, 27'(poll_p));
        write_cfg(CFG_CURRENT_LIMIT, 27'(limit));
        write_cfg(CFG_FAULT_HOLD, fault_h);
        write_cfg(CFG_ACTIVITY_HOLD, act_h);
        settings_applied++;
    endtask

    // Mostly in-range currents, some near the limit, some past saturation
    function automatic logic signed [19:0] random_current();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 20'(int'($urandom_range(0, 800000)) - 400000);
        else if (pick < 8)
            return 20'(int'(model_cfg.current_limit) + int'($urandom_range(0, 4)) - 2);
        else
            return 20'($urandom);
    endfunction

    // Random item: time moves forward mostly in step with the tick period
    task automatic send_random_item();
        probe_item_t it;
        int unsigned base;
        int          pick;
        base = (model_cfg.tick_period == 0) ? 32'd1 : 32'(model_cfg.tick_period);
        it.cmd     = 8'($urandom);
        it.resp2   = 8'($urandom);
        it.resp3   = 8'($urandom);
        it.poll_ok = ($urandom_range(0, 7) != 0);
        it.cur     = random_current();
        it.usb     = 1'($urandom);
        if ($urandom_range(0, 99) < 30) begin
            it.op = OP_EVENT;
            sim_now_us += $urandom_range(0, base / 2);
            case ($urandom_range(0, 9))
                0, 1:    it.cmd = CMD_XFER_A;
                2, 3:    it.cmd = CMD_XFER_B;
                4, 5:    it.cmd = CMD_XFER_C;
                default: ;
            endcase
            // keep faults rarer than plain activity
            if ($urandom_range(0, 3) != 0) begin
                it.resp2 &= ~ACK_FAULT_MASK;
                it.resp3 &= ~ACK_FAULT_MASK;
            end
        end else begin
            it.op = OP_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                sim_now_us += $urandom_range(0, base - 1);    // lands inside the gate
            else if (pick < 16)
                sim_now_us = $urandom;                        // arbitrary jump
            else
                sim_now_us += base + $urandom_range(0, base);
        end
        it.now = sim_now_us;
        send_item(it);
    endtask

    // Random run with one full drain halfway through
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                wait_drained();
            send_random_item();
        end
    endtask

    // Reset-default registers: gate, polls, priority order, saturation, wrap
    task automatic test_default_priority();
        send_tick(32'd0, 1'b1, 20'd0, 1'b1);               // inside the gate after reset
        send_tick(32'd10000, 1'b1, 20'd0, 1'b1);           // unhealthy before first poll
        send_xfer(32'd10100, 8'h00, 8'hff, 8'hff);         // other command
        send_xfer(32'd10200, 8'hff, 8'hff, 8'hff);
        send_tick(32'd100000, 1'b1, 20'd0, 1'b1);          // first poll, green
        send_tick(32'd105000, 1'b1, 20'h7ffff, 1'b1);      // gated
        send_xfer(32'd110000, CMD_XFER_C, 8'hff, 8'hff);   // activity, never a fault
        send_tick(32'd120000, 1'b0, 20'd0, 1'b0);          // amber
        send_xfer(32'd130000, CMD_XFER_A, 8'h04, 8'h00);   // fault via byte two
        send_tick(32'd140000, 1'b1, 20'd0, 1'b1);          // red from fault
        send_xfer(32'd150000, CMD_XFER_B, 8'h00, 8'h10);   // fault via byte three
        send_xfer(32'd160000, CMD_XFER_A, 8'he3, 8'h1c);   // ack clean, wrong byte ignored
        send_tick(32'd1200000, 1'b1, 20'h7ffff, 1'b1);     // saturates high, over budget
        send_tick(32'd1300000, 1'b0, 20'hfffff, 1'b1);     // failed poll keeps stale current
        send_tick(32'd1400000, 1'b1, 20'h80000, 1'b1);     // saturates low, holds expired
        send_tick(32'd1500000, 1'b1, 20'd50000, 1'b0);     // exactly at limit
        send_tick(32'd1600000, 1'b1, 20'd50001, 1'b0);     // just over limit
        send_tick(32'd1700000, 1'b1, 20'hfffff, 1'b0);     // minus one
        send_xfer(32'hffff_ff00, CMD_XFER_C, 8'h00, 8'h00);
        send_tick(32'hffff_ffff, 1'b1, 20'd10, 1'b1);      // amber near wrap
        send_tick(32'h0000_3000, 1'b1, 20'd10, 1'b1);      // across the wrap
        send_tick(32'h0000_3001, 1'b1, 20'd10, 1'b1);      // gated after wrap
        sim_now_us = 32'h0000_3000;
    endtask

    // Zero periods and holds: every tick passes and polls, holds never count
    task automatic test_low_extremes();
        apply_settings(20'd0, 24'd0, 19'd0, 27'd0, 27'd0);
        sim_now_us = 32'hffff_fff0;
        run_random(60);
    endtask

    // Long periods and holds, current limit at the saturation bound
    task automatic test_high_extremes();
        apply_settings(20'd1000000, 24'd10000000, 19'd400000, 27'd100000000, 27'd100000000);
        sim_now_us = 32'hfff0_0000;
        run_random(60);
    endtask

    // Moderate settings, one fixed, one random, one with unit periods
    task automatic test_mixed_settings();
        apply_settings(20'd500, 24'd2000, 19'd100000, 27'd2000, 27'd4000);
        run_random(60);
        apply_settings(20'($urandom_range(1, 5000)), 24'($urandom_range(1, 20000)),
                       19'($urandom_range(0, 400000)), 27'($urandom_range(0, 20000)),
                       27'($urandom_range(0, 20000)));
        run_random(60);
        apply_settings(20'd1, 24'd1, 19'd200000, 27'd50, 27'd120);
        run_random(60);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        apply_settings(20'd300, 24'd1200, 19'd150000, 27'd900, 27'd2500);
        idle_on = 1'b0;
        run_random(80);
    endtask

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        sim_now_us    = '0;
        clear_led_model();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_priority();
        test_low_extremes();
        test_high_extremes();
        test_mixed_settings();
        test_full_rate();
        wait_drained();

        $display("Sent %0d transfer events and %0d ticks under %0d register settings.",
                 xfers_sent, ticks_sent, settings_applied + 1);
        $display("Checked %0d LED results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("status_led_priority_monitor regression: pass");
        end else begin
            $display("status_led_priority_monitor regression: fail");
        end
        $finish;
    end

endmodule
